### rtl/vipm_pkg.sv
// shared types, constants and helper functions of the interrupt pacer and rate meter
`timescale 1ns / 1ps
package vipm_pkg;

    // time and field widths
    localparam int TIME_BITS  = 32;
    localparam int WAIT_W     = 20;
    localparam int RATE_W     = 16;
    localparam int COUNT_W    = 16;
    localparam int PERIOD_W   = 24;
    localparam int PROD_W     = 48;
    localparam int MUL_A_W    = 24;
    localparam int MUL_B_W    = 27;
    localparam int DIV_BITS   = 48;
    localparam int DIV_CNT_W  = $clog2(DIV_BITS);
    localparam int CFG_AW     = 4;
    localparam int CFG_DW     = 32;

    // timing constants
    localparam logic [TIME_BITS-1:0] WINDOW_US   = 32'd500000;
    localparam logic [TIME_BITS-1:0] IDLE_US     = 32'd1000000;
    localparam logic [TIME_BITS-1:0] WAIT_LIMIT  = 32'd1000000;
    localparam logic [MUL_B_W-1:0]   CENTI_SCALE = 27'd100000000;
    localparam logic [RATE_W-1:0]    SAT16       = 16'hFFFF;
    localparam logic [PERIOD_W-1:0]  PERIOD_MAX  = 24'hFFFFFF;
    localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 24'd16667;

    // region rates
    localparam logic [5:0] HZ_PAL  = 6'd50;
    localparam logic [5:0] HZ_NTSC = 6'd60;

    // register reset values
    localparam logic [9:0] PCT_DEFAULT = 10'd100;
    localparam logic [1:0] LIMIT_RESET = 2'd1;

    // event codes
    localparam logic [1:0] FUNC_VI    = 2'd0;
    localparam logic [1:0] FUNC_FRAME = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // pacing modes
    localparam logic [1:0] LIMIT_OFF   = 2'd0;
    localparam logic [1:0] LIMIT_FRAME = 2'd2;

    // register indexes
    localparam logic [1:0] REG_COUNTRY = 2'd0;
    localparam logic [1:0] REG_USE_PCT = 2'd1;
    localparam logic [1:0] REG_SPEED   = 2'd2;
    localparam logic [1:0] REG_LIMIT   = 2'd3;

    // datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
    localparam logic [OP_W-1:0] OP_PER_MUL    = 4'd1;
    localparam logic [OP_W-1:0] OP_PER_START  = 4'd2;
    localparam logic [OP_W-1:0] OP_PER_WAIT   = 4'd3;
    localparam logic [OP_W-1:0] OP_VI_M1      = 4'd4;
    localparam logic [OP_W-1:0] OP_VI_M2      = 4'd5;
    localparam logic [OP_W-1:0] OP_VI_T       = 4'd6;
    localparam logic [OP_W-1:0] OP_FRAME      = 4'd7;
    localparam logic [OP_W-1:0] OP_TICK       = 4'd8;
    localparam logic [OP_W-1:0] OP_WIN        = 4'd9;
    localparam logic [OP_W-1:0] OP_RATE_MUL   = 4'd10;
    localparam logic [OP_W-1:0] OP_RATE_START = 4'd11;
    localparam logic [OP_W-1:0] OP_RATE_WAIT  = 4'd12;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            in_take;
        logic            out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       den_zero;
        logic       win_rate;
        logic       div_done;
        logic       out_free;
    } status_t;

    // pal region codes run at 50 hz
    function automatic logic [5:0] region_hz(input logic [7:0] code);
        logic [5:0] hz;
        case (code)
            8'h44, 8'h46, 8'h49, 8'h50,
            8'h53, 8'h55, 8'h58, 8'h59: hz = HZ_PAL;
            default:                    hz = HZ_NTSC;
        endcase
        return hz;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v != SAT16) ? v + 16'd1 : v;
    endfunction

endpackage

### rtl/vipm_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module vipm_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [vipm_pkg::DIV_BITS-1:0]        dividend,
    input  logic [vipm_pkg::TIME_BITS-1:0]       divisor,
    output logic                                 done,
    output logic [vipm_pkg::DIV_BITS-1:0]        quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [vipm_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [vipm_pkg::TIME_BITS-1:0]    rem_reg, rem_next;
    logic [vipm_pkg::DIV_BITS-1:0]     quo_reg, quo_next;
    logic [vipm_pkg::TIME_BITS-1:0]    dvs_reg, dvs_next;

    logic [vipm_pkg::TIME_BITS:0]      shifted;
    logic [vipm_pkg::TIME_BITS:0]      trial;
    logic                              fits;

    assign shifted = {rem_reg, quo_reg[vipm_pkg::DIV_BITS-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[vipm_pkg::TIME_BITS-1:0]
                            : shifted[vipm_pkg::TIME_BITS-1:0];
            quo_next = {quo_reg[vipm_pkg::DIV_BITS-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == vipm_pkg::DIV_CNT_W'(vipm_pkg::DIV_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/vipm_dp.sv
// datapath: configuration and state registers, shared multiplier, divider, result register
`timescale 1ns / 1ps
module vipm_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  vipm_pkg::cmd_t                     cmd,
    output vipm_pkg::status_t                  status,
    input  logic [1:0]                         func,
    input  logic [vipm_pkg::TIME_BITS-1:0]     now_us,
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_idx,
    input  logic [vipm_pkg::CFG_DW-1:0]        cfg_wdata,
    output logic [vipm_pkg::CFG_DW-1:0]        cfg_rdata,
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic [vipm_pkg::WAIT_W-1:0]        wait_us,
    output logic [vipm_pkg::RATE_W-1:0]        frame_rate_centi,
    output logic [vipm_pkg::RATE_W-1:0]        vi_rate_centi
);

    localparam int TB = vipm_pkg::TIME_BITS;
    localparam int CW = vipm_pkg::COUNT_W;
    localparam int RW = vipm_pkg::RATE_W;
    localparam int PW = vipm_pkg::PERIOD_W;

    // configuration
    logic [7:0]    country_reg, country_next;
    logic          use_reg, use_next;
    logic [9:0]    speed_reg, speed_next;
    logic [1:0]    limit_reg, limit_next;

    // pacing and metering state
    logic [PW-1:0] period_reg, period_next;
    logic [CW-1:0] vi_count_reg, vi_count_next;
    logic [CW-1:0] vi_wc_reg, vi_wc_next;
    logic [TB-1:0] vi_ws_reg, vi_ws_next;
    logic [TB-1:0] vi_last_reg, vi_last_next;
    logic          flag_reg, flag_next;
    logic [CW-1:0] fr_count_reg, fr_count_next;
    logic [TB-1:0] fr_ws_reg, fr_ws_next;
    logic [RW-1:0] fr_rate_reg, fr_rate_next;
    logic [RW-1:0] vi_rate_reg, vi_rate_next;
    logic [TB-1:0] fr_last_reg, fr_last_next;

    // working registers of the current item
    logic [1:0]                   func_reg, func_next;
    logic [TB-1:0]                cur_reg, cur_next;
    logic [vipm_pkg::WAIT_W-1:0]  wait_reg, wait_next;
    logic                         hit_reg, hit_next;
    logic [vipm_pkg::PROD_W-1:0]  prod_reg, prod_next;

    // result register
    logic                         ov_reg, ov_next;
    logic [vipm_pkg::WAIT_W-1:0]  ow_reg, ow_next;
    logic [RW-1:0]                ofr_reg, ofr_next;
    logic [RW-1:0]                ovr_reg, ovr_next;

    // shared multiplier
    logic [vipm_pkg::MUL_A_W-1:0] mul_a;
    logic [vipm_pkg::MUL_B_W-1:0] mul_b;
    logic [vipm_pkg::MUL_A_W+vipm_pkg::MUL_B_W-1:0] mul_p;

    // divider
    logic                           div_start;
    logic [vipm_pkg::DIV_BITS-1:0]  div_dvd;
    logic [TB-1:0]                  div_dvs;
    logic                           div_done;
    logic [vipm_pkg::DIV_BITS-1:0]  div_q;

    logic          sel_vi;
    logic [TB-1:0] ws_sel;
    logic [CW-1:0] cnt_sel;
    logic [TB-1:0] elapsed;
    logic          ahead;
    logic          pace_en;
    logic [TB-1:0] vi_dif;
    logic [TB-1:0] target;
    logic [TB-1:0] pace_diff;
    logic [9:0]    pct;
    logic [15:0]   den;
    logic [RW-1:0] rate_q;
    logic [PW-1:0] period_q;
    logic          out_free;

    assign sel_vi    = func_reg == vipm_pkg::FUNC_VI;
    assign ws_sel    = sel_vi ? vi_ws_reg : fr_ws_reg;
    assign cnt_sel   = sel_vi ? vi_count_reg : fr_count_reg;
    assign elapsed   = cur_reg - ws_sel;
    assign ahead     = ws_sel > cur_reg;
    assign pace_en   = (limit_reg != vipm_pkg::LIMIT_OFF)
                     && !((limit_reg == vipm_pkg::LIMIT_FRAME) && !flag_reg);
    assign vi_dif    = cur_reg - vi_last_reg;
    assign target    = vi_ws_reg + prod_reg[TB-1:0];
    assign pace_diff = target - cur_reg;
    assign pct       = use_reg ? speed_reg : vipm_pkg::PCT_DEFAULT;
    assign den       = prod_reg[15:0];
    assign rate_q    = (div_q[vipm_pkg::DIV_BITS-1:RW] != '0) ? vipm_pkg::SAT16
                                                              : div_q[RW-1:0];
    assign period_q  = (div_q[vipm_pkg::DIV_BITS-1:PW] != '0) ? vipm_pkg::PERIOD_MAX
                                                              : div_q[PW-1:0];
    assign out_free  = !ov_reg || !out_stall;

    // operand select for the one multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            vipm_pkg::OP_PER_MUL:
            begin
                mul_a = {18'd0, vipm_pkg::region_hz(country_reg)};
                mul_b = {17'd0, pct};
            end
            vipm_pkg::OP_VI_M1:
            begin
                mul_a = period_reg;
                mul_b = {10'd0, {1'b0, vi_wc_reg} + 17'd1};
            end
            vipm_pkg::OP_VI_M2:
            begin
                mul_a = period_reg;
                mul_b = {11'd0, vi_count_reg};
            end
            vipm_pkg::OP_RATE_MUL:
            begin
                mul_a = {8'd0, cnt_sel};
                mul_b = vipm_pkg::CENTI_SCALE;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        country_next  = country_reg;
        use_next      = use_reg;
        speed_next    = speed_reg;
        limit_next    = limit_reg;
        period_next   = period_reg;
        vi_count_next = vi_count_reg;
        vi_wc_next    = vi_wc_reg;
        vi_ws_next    = vi_ws_reg;
        vi_last_next  = vi_last_reg;
        flag_next     = flag_reg;
        fr_count_next = fr_count_reg;
        fr_ws_next    = fr_ws_reg;
        fr_rate_next  = fr_rate_reg;
        vi_rate_next  = vi_rate_reg;
        fr_last_next  = fr_last_reg;
        func_next     = func_reg;
        cur_next      = cur_reg;
        wait_next     = wait_reg;
        hit_next      = hit_reg;
        prod_next     = prod_reg;
        div_start     = 1'b0;
        div_dvd       = prod_reg;
        div_dvs       = elapsed;

        if (cmd.in_take)
        begin
            func_next = func;
            cur_next  = now_us;
            wait_next = '0;
        end

        case (cmd.op)
            vipm_pkg::OP_PER_MUL:
            begin
                prod_next = mul_p[vipm_pkg::PROD_W-1:0];
            end
            vipm_pkg::OP_PER_START:
            begin
                // rounded to nearest, half up
                div_dvd = {21'd0, vipm_pkg::CENTI_SCALE} + {33'd0, den[15:1]};
                div_dvs = {16'd0, den};
                if (den == '0)
                    period_next = vipm_pkg::PERIOD_MAX;
                else
                    div_start = 1'b1;
            end
            vipm_pkg::OP_PER_WAIT:
            begin
                if (div_done)
                    period_next = period_q;
            end
            vipm_pkg::OP_VI_M1:
            begin
                prod_next     = mul_p[vipm_pkg::PROD_W-1:0];
                vi_count_next = vipm_pkg::sat_inc(vi_count_reg);
            end
            vipm_pkg::OP_VI_M2:
            begin
                hit_next  = pace_en && ({16'd0, vi_dif} < prod_reg);
                prod_next = mul_p[vipm_pkg::PROD_W-1:0];
                if ((limit_reg != vipm_pkg::LIMIT_OFF) && !pace_en)
                    vi_wc_next = vipm_pkg::sat_inc(vi_wc_reg);
            end
            vipm_pkg::OP_VI_T:
            begin
                if (hit_reg)
                begin
                    // time moves on to the target even when no wait is reported
                    if (!pace_diff[TB-1] && (pace_diff != '0)
                        && (pace_diff < vipm_pkg::WAIT_LIMIT))
                        wait_next = pace_diff[vipm_pkg::WAIT_W-1:0];
                    cur_next = target;
                end
                if (pace_en)
                begin
                    flag_next  = 1'b0;
                    vi_wc_next = '0;
                end
            end
            vipm_pkg::OP_FRAME:
            begin
                fr_count_next = vipm_pkg::sat_inc(fr_count_reg);
                flag_next     = 1'b1;
                fr_last_next  = cur_reg;
            end
            vipm_pkg::OP_TICK:
            begin
                if ((cur_reg - fr_last_reg) > vipm_pkg::IDLE_US)
                    fr_rate_next = '0;
                if ((cur_reg - vi_last_reg) > vipm_pkg::IDLE_US)
                    vi_rate_next = '0;
            end
            vipm_pkg::OP_WIN:
            begin
                if (sel_vi)
                    vi_last_next = cur_reg;
                // window start ahead of now: restart without a rate
                if (ahead)
                begin
                    if (sel_vi)
                    begin
                        vi_ws_next    = cur_reg;
                        vi_count_next = '0;
                    end
                    else
                    begin
                        fr_ws_next    = cur_reg;
                        fr_count_next = '0;
                    end
                end
            end
            vipm_pkg::OP_RATE_MUL:
            begin
                prod_next = mul_p[vipm_pkg::PROD_W-1:0];
            end
            vipm_pkg::OP_RATE_START:
            begin
                div_start = 1'b1;
            end
            vipm_pkg::OP_RATE_WAIT:
            begin
                if (div_done)
                begin
                    if (sel_vi)
                    begin
                        vi_rate_next  = rate_q;
                        vi_ws_next    = cur_reg;
                        vi_count_next = '0;
                    end
                    else
                    begin
                        fr_rate_next  = rate_q;
                        fr_ws_next    = cur_reg;
                        fr_count_next = '0;
                    end
                end
            end
            default:
            begin
                prod_next = prod_reg;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_idx)
                vipm_pkg::REG_COUNTRY:
                begin
                    country_next = cfg_wdata[7:0];
                    flag_next    = 1'b0;
                end
                vipm_pkg::REG_USE_PCT:
                begin
                    use_next  = cfg_wdata[0];
                    flag_next = 1'b0;
                end
                vipm_pkg::REG_SPEED:
                begin
                    speed_next = cfg_wdata[9:0];
                    flag_next  = 1'b0;
                end
                vipm_pkg::REG_LIMIT:
                begin
                    limit_next = cfg_wdata[1:0];
                end
                default:
                begin
                    limit_next = limit_reg;
                end
            endcase
        end
    end

    // result register
    always_comb
    begin
        ov_next  = ov_reg;
        ow_next  = ow_reg;
        ofr_next = ofr_reg;
        ovr_next = ovr_reg;
        if (cmd.out_load)
        begin
            ov_next  = 1'b1;
            ow_next  = wait_reg;
            ofr_next = fr_rate_reg;
            ovr_next = vi_rate_reg;
        end
        else if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
    end

    always_comb
    begin
        case (cfg_idx)
            vipm_pkg::REG_COUNTRY: cfg_rdata = {24'd0, country_reg};
            vipm_pkg::REG_USE_PCT: cfg_rdata = {31'd0, use_reg};
            vipm_pkg::REG_SPEED:   cfg_rdata = {22'd0, speed_reg};
            vipm_pkg::REG_LIMIT:   cfg_rdata = {30'd0, limit_reg};
            default:               cfg_rdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            country_reg  <= '0;
            use_reg      <= 1'b0;
            speed_reg    <= vipm_pkg::PCT_DEFAULT;
            limit_reg    <= vipm_pkg::LIMIT_RESET;
            period_reg   <= vipm_pkg::PERIOD_RESET;
            vi_count_reg <= '0;
            vi_wc_reg    <= '0;
            vi_ws_reg    <= '0;
            vi_last_reg  <= '0;
            flag_reg     <= 1'b0;
            fr_count_reg <= '0;
            fr_ws_reg    <= '0;
            fr_rate_reg  <= '0;
            vi_rate_reg  <= '0;
            fr_last_reg  <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            country_reg  <= country_next;
            use_reg      <= use_next;
            speed_reg    <= speed_next;
            limit_reg    <= limit_next;
            period_reg   <= period_next;
            vi_count_reg <= vi_count_next;
            vi_wc_reg    <= vi_wc_next;
            vi_ws_reg    <= vi_ws_next;
            vi_last_reg  <= vi_last_next;
            flag_reg     <= flag_next;
            fr_count_reg <= fr_count_next;
            fr_ws_reg    <= fr_ws_next;
            fr_rate_reg  <= fr_rate_next;
            vi_rate_reg  <= vi_rate_next;
            fr_last_reg  <= fr_last_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        cur_reg  <= cur_next;
        wait_reg <= wait_next;
        hit_reg  <= hit_next;
        prod_reg <= prod_next;
        ow_reg   <= ow_next;
        ofr_reg  <= ofr_next;
        ovr_reg  <= ovr_next;
    end

    vipm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    assign status.func     = func_reg;
    assign status.den_zero = den == '0;
    assign status.win_rate = !ahead && (elapsed >= vipm_pkg::WINDOW_US);
    assign status.div_done = div_done;
    assign status.out_free = out_free;

    assign out_valid        = ov_reg;
    assign wait_us          = ow_reg;
    assign frame_rate_centi = ofr_reg;
    assign vi_rate_centi    = ovr_reg;

endmodule

### rtl/vipm_ctrl.sv
// controller state machine sequencing the datapath for each item and period update
`timescale 1ns / 1ps
module vipm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               cfg_recalc,
    input  vipm_pkg::status_t  status,
    output vipm_pkg::cmd_t     cmd,
    output logic               in_stall
);

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_DISPATCH   = 4'd1;
    localparam logic [3:0] ST_PER_MUL    = 4'd2;
    localparam logic [3:0] ST_PER_START  = 4'd3;
    localparam logic [3:0] ST_PER_WAIT   = 4'd4;
    localparam logic [3:0] ST_VI_M1      = 4'd5;
    localparam logic [3:0] ST_VI_M2      = 4'd6;
    localparam logic [3:0] ST_VI_T       = 4'd7;
    localparam logic [3:0] ST_FRAME      = 4'd8;
    localparam logic [3:0] ST_TICK       = 4'd9;
    localparam logic [3:0] ST_WIN        = 4'd10;
    localparam logic [3:0] ST_RATE_MUL   = 4'd11;
    localparam logic [3:0] ST_RATE_START = 4'd12;
    localparam logic [3:0] ST_RATE_WAIT  = 4'd13;
    localparam logic [3:0] ST_FIN        = 4'd14;

    logic [3:0] state_reg, state_next;
    logic       pending_reg, pending_next;
    logic       take;

    assign in_stall = (state_reg != ST_IDLE) || pending_reg;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg || cfg_recalc;
        cmd.op       = vipm_pkg::OP_NONE;
        cmd.in_take  = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (pending_reg)
                begin
                    state_next   = ST_PER_MUL;
                    pending_next = cfg_recalc;
                end
                else if (take)
                begin
                    cmd.in_take = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.func)
                    vipm_pkg::FUNC_VI:    state_next = ST_VI_M1;
                    vipm_pkg::FUNC_FRAME: state_next = ST_FRAME;
                    vipm_pkg::FUNC_TICK:  state_next = ST_TICK;
                    default:              state_next = ST_FIN;
                endcase
            end
            ST_PER_MUL:
            begin
                cmd.op     = vipm_pkg::OP_PER_MUL;
                state_next = ST_PER_START;
            end
            ST_PER_START:
            begin
                cmd.op     = vipm_pkg::OP_PER_START;
                state_next = status.den_zero ? ST_IDLE : ST_PER_WAIT;
            end
            ST_PER_WAIT:
            begin
                cmd.op = vipm_pkg::OP_PER_WAIT;
                if (status.div_done)
                    state_next = ST_IDLE;
            end
            ST_VI_M1:
            begin
                cmd.op     = vipm_pkg::OP_VI_M1;
                state_next = ST_VI_M2;
            end
            ST_VI_M2:
            begin
                cmd.op     = vipm_pkg::OP_VI_M2;
                state_next = ST_VI_T;
            end
            ST_VI_T:
            begin
                cmd.op     = vipm_pkg::OP_VI_T;
                state_next = ST_WIN;
            end
            ST_FRAME:
            begin
                cmd.op     = vipm_pkg::OP_FRAME;
                state_next = ST_WIN;
            end
            ST_TICK:
            begin
                cmd.op     = vipm_pkg::OP_TICK;
                state_next = ST_FIN;
            end
            ST_WIN:
            begin
                cmd.op     = vipm_pkg::OP_WIN;
                state_next = status.win_rate ? ST_RATE_MUL : ST_FIN;
            end
            ST_RATE_MUL:
            begin
                cmd.op     = vipm_pkg::OP_RATE_MUL;
                state_next = ST_RATE_START;
            end
            ST_RATE_START:
            begin
                cmd.op     = vipm_pkg::OP_RATE_START;
                state_next = ST_RATE_WAIT;
            end
            ST_RATE_WAIT:
            begin
                cmd.op = vipm_pkg::OP_RATE_WAIT;
                if (status.div_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

endmodule

### rtl/video_interrupt_pacer_rate_meter_top.sv
// top level of the video interrupt pacer and rate meter
//
// usage:
//   input channel (in_valid / in_stall, func, now_us) carries one timestamped
//   event per item: vertical interrupt, frame drawn or idle tick
//   output channel (out_valid / out_stall) returns exactly one item per input
//   item: wait_us (nonzero only for a paced interrupt) plus both measured rates
//   an item is accepted on a clock edge with valid high and stall low
//   apb port holds the region code, speed-percent enable, speed percent and
//   pacing mode at byte addresses 0, 4, 8, 12; pready is always high
// sequencing:
//   one item at a time; when a rate window closes the item also uses the shared
//   divider; a write to any of the first three registers recomputes the target
//   period on the same divider and holds in_stall meanwhile
// reset:
//   rst_n clears the control, pacing and rate state; registers return to
//   their defaults, period is 16667 us, rates read zero and no item is pending
// back pressure:
//   the result waits in the output register while out_stall is high; the next
//   item is already accepted and worked on, and only its final load waits
`timescale 1ns / 1ps
module video_interrupt_pacer_rate_meter_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // event input
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         func,
    input  logic [vipm_pkg::TIME_BITS-1:0]     now_us,
    // result output
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [vipm_pkg::WAIT_W-1:0]        wait_us,
    output logic [vipm_pkg::RATE_W-1:0]        frame_rate_centi,
    output logic [vipm_pkg::RATE_W-1:0]        vi_rate_centi,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [vipm_pkg::CFG_AW-1:0]        paddr,
    input  logic [vipm_pkg::CFG_DW-1:0]        pwdata,
    output logic [vipm_pkg::CFG_DW-1:0]        prdata,
    output logic                               pready
);

    vipm_pkg::cmd_t    cmd;
    vipm_pkg::status_t status;
    logic              cfg_we;
    logic [1:0]        cfg_idx;
    logic              cfg_recalc;

    // word addressed registers, written in the access phase
    assign pready     = 1'b1;
    assign cfg_idx    = paddr[3:2];
    assign cfg_we     = psel && penable && pwrite && pready;
    // anything but the pacing mode changes the target period
    assign cfg_recalc = cfg_we && (cfg_idx != vipm_pkg::REG_LIMIT);

    vipm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .cfg_recalc (cfg_recalc),
        .status     (status),
        .cmd        (cmd),
        .in_stall   (in_stall)
    );

    vipm_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .func             (func),
        .now_us           (now_us),
        .cfg_we           (cfg_we),
        .cfg_idx          (cfg_idx),
        .cfg_wdata        (pwdata),
        .cfg_rdata        (prdata),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .wait_us          (wait_us),
        .frame_rate_centi (frame_rate_centi),
        .vi_rate_centi    (vi_rate_centi)
    );

    // one item in flight: the input closes right after an acceptance
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while an item is in flight");

    // a reported wait never reaches one second
    a_wait_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> wait_us < 20'd1000000)
        else $error("wait out of range");

    // a period update blocks new items until it is done
    a_recalc_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_recalc |=> in_stall)
        else $error("input open during period update");

endmodule

### bench/pacer_checker.sv
// checker that predicts the pacer and rate meter results and compares them at the output
`timescale 1ns / 1ps
module pacer_checker
    import vipm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [1:0]             func,
    input  logic [TIME_BITS-1:0]   now_us,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [WAIT_W-1:0]      wait_us,
    input  logic [RATE_W-1:0]      frame_rate_centi,
    input  logic [RATE_W-1:0]      vi_rate_centi,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_AW-1:0]      paddr,
    input  logic [CFG_DW-1:0]      pwdata,
    input  logic                   pready,
    output logic                   busy,
    output int                     fail_count
);

    localparam logic [63:0] CENTI     = 64'd100000000;
    localparam logic [31:0] WIN_SPAN  = 32'd500000;
    localparam logic [31:0] IDLE_SPAN = 32'd1000000;
    localparam logic [31:0] WAIT_CAP  = 32'd1000000;

    typedef struct packed {
        logic [WAIT_W-1:0] pace_wait;
        logic [RATE_W-1:0] frame_centi;
        logic [RATE_W-1:0] vi_centi;
    } pacer_result_t;

    pacer_result_t pending_results[$];
    int fails = 0;
    int n_results = 0;

    // register copies
    logic [7:0]          region;
    logic                use_pct;
    logic [9:0]          pct;
    logic [1:0]          mode;

    // pacing and rate state
    logic [PERIOD_W-1:0] period;
    logic [COUNT_W-1:0]  vi_cnt, vi_held, frm_cnt;
    logic [31:0]         vi_win, vi_prev, frm_win, frm_prev;
    logic                drawn;
    logic [RATE_W-1:0]   frm_rate, vi_rate;

    assign fail_count = fails;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fails++;
    endtask

    function automatic logic [15:0] bump(input logic [15:0] v);
        return v + {15'b0, (v != 16'hFFFF)};
    endfunction

    function automatic logic [5:0] field_rate_hz(input logic [7:0] code);
        logic [5:0] hz;
        hz = 6'd60;
        case (code)
            8'h44, 8'h46, 8'h49, 8'h50, 8'h53, 8'h55, 8'h58, 8'h59: hz = 6'd50;
            default: ;
        endcase
        return hz;
    endfunction

    function automatic logic [15:0] centi_rate(input logic [15:0] cnt, input logic [31:0] span);
        logic [63:0] num, den, r;
        num = cnt;
        num = num * CENTI;
        den = span;
        r = num / den;
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    task automatic retune_period();
        logic [63:0] den, p;
        den = field_rate_hz(region);
        den = den * (use_pct ? pct : 10'd100);
        if (den == 0)
            p = 64'hFF_FFFF;
        else
            p = (CENTI + den / 2) / den;
        if (p > 64'hFF_FFFF)
            p = 64'hFF_FFFF;
        period = p[PERIOD_W-1:0];
        drawn = 1'b0;
    endtask

    task automatic clear_model();
        region = 8'd0;
        use_pct = 1'b0;
        pct = PCT_DEFAULT;
        mode = LIMIT_RESET;
        period = PERIOD_RESET;
        vi_cnt = '0;
        vi_held = '0;
        frm_cnt = '0;
        vi_win = '0;
        vi_prev = '0;
        frm_win = '0;
        frm_prev = '0;
        drawn = 1'b0;
        frm_rate = '0;
        vi_rate = '0;
    endtask

    task automatic apply_write(input logic [1:0] idx, input logic [31:0] data);
        case (idx)
            REG_COUNTRY: begin region = data[7:0]; retune_period(); end
            REG_USE_PCT: begin use_pct = data[0]; retune_period(); end
            REG_SPEED:   begin pct = data[9:0]; retune_period(); end
            REG_LIMIT:   mode = data[1:0];
            default: ;
        endcase
    endtask

    task automatic on_interrupt(input logic [31:0] now, output logic [WAIT_W-1:0] pace);
        logic [31:0] cur, gap, target, diff, span;
        logic [63:0] budget, p64, prod;
        cur = now;
        pace = '0;
        gap = cur - vi_prev;
        vi_cnt = bump(vi_cnt);
        if (mode != LIMIT_OFF) begin
            if (mode == LIMIT_FRAME && !drawn) begin
                vi_held = bump(vi_held);
            end
            else begin
                p64 = period;
                budget = vi_held;
                budget = p64 * (budget + 64'd1);
                if ({32'b0, gap} < budget) begin
                    prod = vi_cnt;
                    prod = p64 * prod;
                    target = vi_win + prod[31:0];
                    diff = target - cur;
                    if (!diff[31] && diff != 0 && diff < WAIT_CAP)
                        pace = diff[WAIT_W-1:0];
                    cur = cur + diff;
                end
                drawn = 1'b0;
                vi_held = '0;
            end
        end
        span = cur - vi_win;
        if (vi_win > cur) begin
            vi_win = cur;
            vi_cnt = '0;
        end
        else if (span >= WIN_SPAN) begin
            vi_rate = centi_rate(vi_cnt, span);
            vi_win = cur;
            vi_cnt = '0;
        end
        vi_prev = cur;
    endtask

    task automatic on_frame(input logic [31:0] now);
        logic [31:0] span;
        span = now - frm_win;
        frm_cnt = bump(frm_cnt);
        drawn = 1'b1;
        if (frm_win > now) begin
            frm_win = now;
            frm_cnt = '0;
        end
        else if (span >= WIN_SPAN) begin
            frm_rate = centi_rate(frm_cnt, span);
            frm_win = now;
            frm_cnt = '0;
        end
        frm_prev = now;
    endtask

    task automatic on_tick(input logic [31:0] now);
        logic [31:0] since_frame, since_vi;
        since_frame = now - frm_prev;
        since_vi = now - vi_prev;
        if (since_frame > IDLE_SPAN)
            frm_rate = '0;
        if (since_vi > IDLE_SPAN)
            vi_rate = '0;
    endtask

    always @(posedge clk) begin : watch
        pacer_result_t want;
        logic [WAIT_W-1:0] pace;
        if (!rst_n) begin
            clear_model();
            pending_results.delete();
            busy <= 1'b0;
        end
        else begin
            if (psel && penable && pwrite && pready)
                apply_write(paddr[CFG_AW-1:2], pwdata);

            if (in_valid && !in_stall) begin
                pace = '0;
                case (func)
                    FUNC_VI:    on_interrupt(now_us, pace);
                    FUNC_FRAME: on_frame(now_us);
                    FUNC_TICK:  on_tick(now_us);
                    default: ;
                endcase
                want.pace_wait = pace;
                want.frame_centi = frm_rate;
                want.vi_centi = vi_rate;
                pending_results.push_back(want);
            end

            if (out_valid && !out_stall) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing pending",
                                              n_results));
                end
                else begin
                    want = pending_results.pop_front();
                    if (wait_us !== want.pace_wait)
                        report_mismatch($sformatf("result %0d wait_us %0d, expected %0d",
                                                  n_results, wait_us, want.pace_wait));
                    if (frame_rate_centi !== want.frame_centi)
                        report_mismatch($sformatf("result %0d frame_rate_centi %0d, expected %0d",
                                                  n_results, frame_rate_centi,
                                                  want.frame_centi));
                    if (vi_rate_centi !== want.vi_centi)
                        report_mismatch($sformatf("result %0d vi_rate_centi %0d, expected %0d",
                                                  n_results, vi_rate_centi, want.vi_centi));
                end
            end

            busy <= (pending_results.size() != 0);
        end
    end

endmodule

### bench/testbench.sv
// top of the pacer and rate meter bench: stimulus, back pressure, watchdog and verdict
`timescale 1ns / 1ps
module testbench;

    // codes the package leaves unnamed
    localparam logic [1:0] FUNC_NONE   = 2'd3;   // ignored event code
    localparam logic [1:0] LIMIT_EACH  = 2'd1;   // pace every interrupt
    localparam logic [1:0] LIMIT_SPARE = 2'd3;   // unused mode, acts like pace-every

    localparam int STALL_PCT      = 36;     // idle chance per cycle on each side
    localparam int HOLD_CYCLES    = 400;    // one long receiver hold-off
    localparam int WATCHDOG_LIMIT = 5000;   // cycles with no handshake at all
    localparam int DRAIN_CYCLES   = 64;     // settling time before the verdict
    localparam int FLAT_RUN       = 30;     // items per burst in the flat-out run

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [1:0]                     func = vipm_pkg::FUNC_VI;
    logic [vipm_pkg::TIME_BITS-1:0] now_us = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [vipm_pkg::WAIT_W-1:0]    wait_us;
    logic [vipm_pkg::RATE_W-1:0]    frame_rate_centi;
    logic [vipm_pkg::RATE_W-1:0]    vi_rate_centi;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [vipm_pkg::CFG_AW-1:0]    paddr = '0;
    logic [vipm_pkg::CFG_DW-1:0]    pwdata = '0;
    logic [vipm_pkg::CFG_DW-1:0]    prdata;
    logic                           pready;

    logic busy;
    int   fail_count;

    // stimulus-to-receiver controls
    logic hold_req = 1'b0;   // ask the receiver for its one long hold-off
    logic no_idle = 1'b0;    // both sides run flat out

    int idle_cycles = 0;

    video_interrupt_pacer_rate_meter_top u_top (.*);

    pacer_checker u_check (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: a long stretch with no handshake on any port means a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // receiver side: random stalls, one long hold-off on request, none while flat out
    initial
    begin : receiver
        int hold_left;
        bit held;
        hold_left = 0;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (no_idle)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < STALL_PCT);
            end
        end
    end

    // offer one event and return at the edge that takes it
    task automatic send_event(input logic [1:0] f, input logic [31:0] t);
        while (!no_idle && $urandom_range(0, 99) < STALL_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        now_us <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // drop valid and wait until every result has come back
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // apb write: setup then access; the block stalls its input while it retunes
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // all four registers, with random junk above each field
    task automatic configure(input logic [7:0] country, input logic use_pct,
                             input logic [9:0] pct, input logic [1:0] mode);
        quiesce();
        reg_write(vipm_pkg::REG_COUNTRY, ($urandom() & 32'hFFFF_FF00) | {24'b0, country});
        reg_write(vipm_pkg::REG_USE_PCT, ($urandom() & 32'hFFFF_FFFE) | {31'b0, use_pct});
        reg_write(vipm_pkg::REG_SPEED,   ($urandom() & 32'hFFFF_FC00) | {22'b0, pct});
        reg_write(vipm_pkg::REG_LIMIT,   ($urandom() & 32'hFFFF_FFFC) | {30'b0, mode});
    endtask

    // hand-picked events under the reset settings: wraps, window restarts,
    // idle clear boundaries, the ignored code
    task automatic run_directed();
        send_event(vipm_pkg::FUNC_VI,    32'd0);
        send_event(vipm_pkg::FUNC_VI,    32'd16667);
        send_event(vipm_pkg::FUNC_VI,    32'd20000);
        send_event(vipm_pkg::FUNC_FRAME, 32'd20000);
        send_event(vipm_pkg::FUNC_VI,    32'd30000);
        send_event(vipm_pkg::FUNC_FRAME, 32'd0);
        send_event(vipm_pkg::FUNC_TICK,  32'd0);
        send_event(FUNC_NONE,            32'hFFFF_FFFF);
        send_event(vipm_pkg::FUNC_FRAME, 32'hFFFF_FFFF);
        send_event(vipm_pkg::FUNC_VI,    32'hFFFF_FFFF);
        // window start now ahead of the time: both windows restart
        send_event(vipm_pkg::FUNC_VI,    32'd5);
        send_event(vipm_pkg::FUNC_FRAME, 32'd7);
        // exactly one second idle does not clear, one more microsecond does
        send_event(vipm_pkg::FUNC_TICK,  32'd1000007);
        send_event(vipm_pkg::FUNC_TICK,  32'd1000008);
        send_event(vipm_pkg::FUNC_TICK,  32'hAAAA_AAAA);
        send_event(FUNC_NONE,            32'h5555_5555);
        send_event(vipm_pkg::FUNC_VI,    32'h8000_0000);
        send_event(vipm_pkg::FUNC_FRAME, 32'h8000_0000);
        send_event(vipm_pkg::FUNC_FRAME, 32'h8007_A120);
        send_event(vipm_pkg::FUNC_VI,    32'h8007_A120);
    endtask

    // random events under one register setting; time mostly creeps forward at
    // about the pacing period, with jumps past the window and idle spans,
    // steps backward and fully random stamps mixed in
    task automatic run_phase(input logic [7:0] country, input logic use_pct,
                             input logic [9:0] pct, input logic [1:0] mode,
                             input int unsigned n_items, input int unsigned step_hi,
                             input logic [31:0] t0, input bit squeeze);
        logic [31:0] t;
        logic [1:0] f;
        int unsigned done, roll;
        configure(country, use_pct, pct, mode);
        t = t0;
        done = 0;
        while (done < n_items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 72)
                t = t + $urandom_range(0, step_hi);
            else if (roll < 82)
                t = t + $urandom_range(400000, 1500000);
            else if (roll < 89)
                t = t - $urandom_range(1, 100000);
            else if (roll < 94)
                t = $urandom();
            roll = $urandom_range(0, 99);
            if (roll < 45)
                f = vipm_pkg::FUNC_VI;
            else if (roll < 78)
                f = vipm_pkg::FUNC_FRAME;
            else if (roll < 94)
                f = vipm_pkg::FUNC_TICK;
            else
                f = FUNC_NONE;
            send_event(f, t);
            if (f != FUNC_NONE)
                done++;
            // the long hold-off lands while the sender keeps offering items
            if (squeeze && done == n_items / 3)
                hold_req <= 1'b1;
        end
    endtask

    initial
    begin : stimulus
        int k;
        logic [31:0] t;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // settings with the extremes: pal and ntsc, speed 0, 10, 1000 and 1023,
        // every pacing mode, percent ignored
        run_phase(8'h44, 1'b1, 10'd100,  LIMIT_EACH,  90, 24000,  32'h0010_0000, 1'b0);
        run_phase(8'hFF, 1'b1, 10'd10,   vipm_pkg::LIMIT_FRAME, 90, 200000, $urandom(), 1'b1);
        run_phase(8'h59, 1'b1, 10'd1023, LIMIT_SPARE, 90, 2000,   32'hFFF0_0000, 1'b0);
        run_phase(8'h00, 1'b1, 10'd0,    LIMIT_EACH,  90, 40000,  $urandom(),    1'b0);
        run_phase(8'($urandom_range(0, 255)), 1'b0, 10'($urandom_range(10, 1000)),
                  vipm_pkg::LIMIT_OFF, 90, 24000, $urandom(), 1'b0);
        run_phase(8'h50, 1'b1, 10'd1000, vipm_pkg::LIMIT_FRAME, 90, 2500, $urandom(), 1'b0);
        for (k = 0; k < 3; k++)
            run_phase(8'($urandom_range(8'h40, 8'h5C)), 1'($urandom_range(0, 1)),
                      10'($urandom_range(0, 1023)), 2'($urandom_range(0, 3)),
                      90, 24000, $urandom(), 1'b0);

        // flat-out run at one instant: mode 2 with no frame holds the interrupts
        // back, then a burst of frames
        configure(8'h53, 1'b1, 10'd100, vipm_pkg::LIMIT_FRAME);
        no_idle <= 1'b1;
        t = $urandom();
        for (k = 0; k < FLAT_RUN; k++)
            send_event(vipm_pkg::FUNC_VI, t);
        for (k = 0; k < FLAT_RUN; k++)
            send_event(vipm_pkg::FUNC_FRAME, t);
        no_idle <= 1'b0;
        quiesce();
        // closing the windows gives fresh rates, then idling clears them
        reg_write(vipm_pkg::REG_LIMIT, {30'b0, vipm_pkg::LIMIT_OFF});
        send_event(vipm_pkg::FUNC_VI,    t + 32'd600000);
        send_event(vipm_pkg::FUNC_FRAME, t + 32'd600000);
        send_event(vipm_pkg::FUNC_TICK,  t + 32'd3000000);

        quiesce();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
